/* design/notc_pkg.sv */
// ----------------------------------------------------------------------------
// notc_pkg
// Shared constants and types for the noisy-or text classifier: table sizes,
// fixed-point format, command codes and the transaction record that moves
// down the chain of label cells.
// ----------------------------------------------------------------------------
package notc_pkg;

  localparam int MAX_LABELS = 16;
  localparam int MAX_TERMS  = 1024;
  localparam int FRAC_BITS  = 15;

  localparam int LABEL_W = $clog2(MAX_LABELS);
  localparam int TERM_W  = $clog2(MAX_TERMS);
  localparam int VAL_W   = 16;
  localparam int COUNT_W = 5;
  localparam int CMD_W   = 2;

  localparam logic [VAL_W-1:0] FX_ONE = VAL_W'(1) << FRAC_BITS;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TERM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [CMD_W-1:0]   cmd;
    logic [LABEL_W-1:0] label_index;
    logic [TERM_W-1:0]  term;
    logic [VAL_W-1:0]   weight;
    logic [COUNT_W-1:0] labels_used;
    logic [LABEL_W-1:0] best;
    logic [VAL_W-1:0]   best_p;
  } token_t;

  typedef struct packed {
    logic              en;
    logic [TERM_W-1:0] addr;
  } clear_t;

endpackage

/* design/notc_cell.sv */
// ----------------------------------------------------------------------------
// notc_cell
// One label of the classifier: its slice of the weight table, its running
// factor and one multiplier. A transaction is registered here, then
// handed to the next cell with the running best label folded in.
// ----------------------------------------------------------------------------
module notc_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [notc_pkg::LABEL_W-1:0] idx,
  input  notc_pkg::clear_t        clr,
  input  notc_pkg::token_t        tok_in,
  output notc_pkg::token_t        tok_out
);
  import notc_pkg::*;

  logic [VAL_W-1:0]   mem [MAX_TERMS];
  logic [VAL_W-1:0]   rdata;
  token_t             tok;
  logic [VAL_W-1:0]   factor;
  logic [VAL_W-1:0]   comp;
  logic [2*VAL_W-1:0] prod;
  logic [VAL_W-1:0]   post;

  always_ff @(posedge clk) begin
    if (clr.en) begin
      mem[clr.addr] <= '0;
    end else if (tok_in.valid && tok_in.cmd == CMD_LOAD && tok_in.label_index == idx) begin
      mem[tok_in.term] <= tok_in.weight;
    end
    rdata <= mem[tok_in.term];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= tok_in.valid;
    end
    tok.cmd         <= tok_in.cmd;
    tok.label_index <= tok_in.label_index;
    tok.term        <= tok_in.term;
    tok.weight      <= tok_in.weight;
    tok.labels_used <= tok_in.labels_used;
    tok.best        <= tok_in.best;
    tok.best_p      <= tok_in.best_p;
  end

  assign comp = (rdata >= FX_ONE) ? '0 : FX_ONE - rdata;
  assign prod = factor * comp;
  assign post = (factor >= FX_ONE) ? '0 : FX_ONE - factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= FX_ONE;
    end else if (tok.valid) begin
      unique case (tok.cmd)
        CMD_TERM: factor <= prod[FRAC_BITS +: VAL_W];
        CMD_END:  factor <= FX_ONE;
        default:  factor <= factor;
      endcase
    end
  end

  always_comb begin
    tok_out = tok;
    if (tok.valid && tok.cmd == CMD_END && {1'b0, idx} < tok.labels_used
        && post >= tok.best_p) begin
      tok_out.best   = idx;
      tok_out.best_p = post;
    end
  end

endmodule

/* design/noisy_or_text_classifier_top.sv */
// ----------------------------------------------------------------------------
// noisy_or_text_classifier_top
// Noisy-or label classifier built as a chain of label cells. Load, term and
// end-of-document transactions enter cell 0 and step one cell per cycle.
//
//   channel   handshake                   payload
//   command   start / busy                command, label_index, term_id,
//                                         weight_value
//   config    cfg_valid / cfg_ready       cfg_data (label_count)
//   result    done (one-cycle strobe)     win_label, best_posterior
//
// Every transaction passes through all label cells; busy stays high until
// it leaves the last cell, so a new one cannot start before then.
// The end-of-document result appears the cycle after it leaves the chain.
// After reset a clearing pass zeroes the weight table, one term row of all
// cells per cycle, with busy high; config is always ready.
// The result side cannot stall.
// ----------------------------------------------------------------------------
module noisy_or_text_classifier_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [notc_pkg::CMD_W-1:0]    command,
  input  logic [notc_pkg::LABEL_W-1:0]  label_index,
  input  logic [notc_pkg::TERM_W-1:0]   term_id,
  input  logic [notc_pkg::VAL_W-1:0]    weight_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [notc_pkg::COUNT_W-1:0]  cfg_data,
  output logic                          done,
  output logic [notc_pkg::LABEL_W-1:0]  win_label,
  output logic [notc_pkg::VAL_W-1:0]    best_posterior
);
  import notc_pkg::*;

  logic [COUNT_W-1:0] label_count;
  logic [COUNT_W-1:0] labels_used;
  logic               clearing;
  logic [TERM_W-1:0]  clr_addr;
  logic               inflight;
  logic               accept;
  clear_t             clr;
  token_t             chain [MAX_LABELS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      label_count <= COUNT_W'(MAX_LABELS);
    end else if (cfg_valid && cfg_ready) begin
      label_count <= cfg_data;
    end
  end

  always_comb begin
    if (label_count == '0) begin
      labels_used = COUNT_W'(1);
    end else if (label_count > COUNT_W'(MAX_LABELS)) begin
      labels_used = COUNT_W'(MAX_LABELS);
    end else begin
      labels_used = label_count;
    end
  end

  // weight table clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + TERM_W'(1);
      if (clr_addr == TERM_W'(MAX_TERMS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign clr.en   = clearing;
  assign clr.addr = clr_addr;

  assign busy   = clearing || (inflight && !chain[MAX_LABELS].valid);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 1'b0;
    end else if (accept) begin
      inflight <= 1'b1;
    end else if (chain[MAX_LABELS].valid) begin
      inflight <= 1'b0;
    end
  end

  always_comb begin
    chain[0].valid       = accept;
    chain[0].cmd         = command;
    chain[0].label_index = label_index;
    chain[0].term        = term_id;
    chain[0].weight      = weight_value;
    chain[0].labels_used = labels_used;
    chain[0].best        = '0;
    chain[0].best_p      = '0;
  end

  for (genvar g = 0; g < MAX_LABELS; g++) begin : g_cell
    notc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (LABEL_W'(g)),
      .clr     (clr),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[MAX_LABELS].valid && chain[MAX_LABELS].cmd == CMD_END;
    end
    win_label      <= chain[MAX_LABELS].best;
    best_posterior <= chain[MAX_LABELS].best_p;
  end

endmodule
